// ----- rtl/nnr_pkg.sv -----
// Shared types, constants and helper functions of the nearest-neighbour rotation unit.
package nnr_pkg;

   localparam int COORD_W       = 9;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int TRIG_W        = 16;
   localparam int PIXEL_W       = 32;
   localparam int PROD_W        = DIFF_W + TRIG_W;
   localparam int REQ_TDATA_W   = 56;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DEF_MAX_SIDE  = 256;
   localparam int DEF_FRAC_BITS = 14;

   localparam logic [COORD_W-1:0]       RST_SRC_WIDTH  = 9'd256;
   localparam logic [COORD_W-1:0]       RST_SRC_HEIGHT = 9'd256;
   localparam logic [COORD_W-1:0]       RST_DST_WIDTH  = 9'd256;
   localparam logic [COORD_W-1:0]       RST_DST_HEIGHT = 9'd256;
   localparam logic signed [TRIG_W-1:0] RST_COS        = 16'sd16384;
   localparam logic signed [TRIG_W-1:0] RST_SIN        = 16'sd0;

   localparam logic [PIXEL_W-1:0] ALPHA_ADD   = 32'hff00_0000;
   localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 32'hffff_ffff;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_DST_WIDTH  = 3'd2,
      REG_DST_HEIGHT = 3'd3,
      REG_COS_ANGLE  = 3'd4,
      REG_SIN_ANGLE  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0]       src_width;
      logic [COORD_W-1:0]       src_height;
      logic [COORD_W-1:0]       dst_width;
      logic [COORD_W-1:0]       dst_height;
      logic signed [TRIG_W-1:0] cos_angle;
      logic signed [TRIG_W-1:0] sin_angle;
   } cfg_type;

   // render: a/b are centred destination offsets; load: a/b are source coordinates
   typedef struct packed {
      logic                     is_render;
      logic signed [DIFF_W-1:0] a;
      logic signed [DIFF_W-1:0] b;
      logic [PIXEL_W-1:0]       pixel;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [COORD_W-1:0] side_limit(input logic [COORD_W-1:0] size,
                                                     input int max_side);
      logic [COORD_W-1:0] lim;
      if (max_side >= (1 << COORD_W)) begin
         lim = size;
      end else if (int'(size) < max_side) begin
         lim = size;
      end else begin
         lim = COORD_W'(max_side);
      end
      return lim;
   endfunction

   function automatic logic [PIXEL_W-1:0] format_pixel(input logic [PIXEL_W-1:0] raw);
      logic [PIXEL_W-1:0] p;
      p = raw + ALPHA_ADD;
      return {p[31:24], p[7:0], p[15:8], p[23:16]};
   endfunction

endpackage

// ----- rtl/nearest_neighbor_rotation_unit.sv -----
// Nearest-neighbour image rotator over a source frame store: top level.
// A render request gives a response after passing the queue, multiply, sum, store read
// and output register; loads give none. Throughput: one request per cycle unless
// rsp_tready stalls the response, set by the single store port used once per request.
// Reset: clears control state and restores the register defaults; the image store
// keeps its contents and is not cleared.
module nearest_neighbor_rotation_unit
   import nnr_pkg::*;
#(
   parameter int MAX_SIDE  = DEF_MAX_SIDE,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // coord_x[8:0], coord_y[17:9], pixel_in[49:18]
   input  logic [0:0]             req_tuser,   // cmd[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // pixel_out[31:0]
   output logic [0:0]             rsp_tuser,   // in_source[0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      keep;
   item_type  front_item;
   item_type  q_item;
   qstat_type q_status;
   logic      q_push;
   logic      q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_SRC_WIDTH:  cfg_in.src_width  = csr_data[COORD_W-1:0];
            REG_SRC_HEIGHT: cfg_in.src_height = csr_data[COORD_W-1:0];
            REG_DST_WIDTH:  cfg_in.dst_width  = csr_data[COORD_W-1:0];
            REG_DST_HEIGHT: cfg_in.dst_height = csr_data[COORD_W-1:0];
            REG_COS_ANGLE:  cfg_in.cos_angle  = $signed(csr_data[TRIG_W-1:0]);
            REG_SIN_ANGLE:  cfg_in.sin_angle  = $signed(csr_data[TRIG_W-1:0]);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= RST_SRC_WIDTH;
         cfg_ff.src_height <= RST_SRC_HEIGHT;
         cfg_ff.dst_width  <= RST_DST_WIDTH;
         cfg_ff.dst_height <= RST_DST_HEIGHT;
         cfg_ff.cos_angle  <= RST_COS;
         cfg_ff.sin_angle  <= RST_SIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nnr_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .cfg      (cfg_ff),
      .cmd      (req_tuser[0]),
      .coord_x  (req_tdata[8:0]),
      .coord_y  (req_tdata[17:9]),
      .pixel_in (req_tdata[49:18]),
      .keep     (keep),
      .item     (front_item)
   );

   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready && keep;

   nnr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .status    (q_status)
   );

   nnr_back #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .pixel_out (rsp_tdata),
      .in_source (rsp_tuser[0])
   );

   a_white_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == WHITE_PIXEL)
      else $error("outside response is not white");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

endmodule

// ----- rtl/nnr_ram.sv -----
// Generic single-port RAM with registered read data.
module nnr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/nnr_front.sv -----
// Front end: classify requests, drop out-of-range loads, centre render coordinates.
module nnr_front
   import nnr_pkg::*;
#(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  cfg_type            cfg,
   input  logic               cmd,
   input  logic [COORD_W-1:0] coord_x,
   input  logic [COORD_W-1:0] coord_y,
   input  logic [PIXEL_W-1:0] pixel_in,
   output logic               keep,
   output item_type           item
);

   logic [COORD_W-1:0]       lim_x;
   logic [COORD_W-1:0]       lim_y;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;

   always_comb begin
      lim_x = side_limit(cfg.src_width, MAX_SIDE);
      lim_y = side_limit(cfg.src_height, MAX_SIDE);
      dx = $signed({1'b0, coord_x}) - $signed({2'b00, cfg.dst_width[COORD_W-1:1]});
      dy = $signed({1'b0, coord_y}) - $signed({2'b00, cfg.dst_height[COORD_W-1:1]});
      keep = cmd || ((coord_x < lim_x) && (coord_y < lim_y));
      item.is_render = cmd;
      item.a = cmd ? dx : $signed(DIFF_W'(coord_x));
      item.b = cmd ? dy : $signed(DIFF_W'(coord_y));
      item.pixel = pixel_in;
   end

endmodule

// ----- rtl/nnr_queue.sv -----
// Short request queue between front end and back end.
module nnr_queue
   import nnr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  pop_item,
   output qstat_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ----- rtl/nnr_back.sv -----
// Back end: rotate, look up the source store, format and hold the response.
module nnr_back
   import nnr_pkg::*;
#(
   parameter int MAX_SIDE  = DEF_MAX_SIDE,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  qstat_type          q_status,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIXEL_W-1:0] pixel_out,
   output logic               in_source
);

   localparam int SIDE_BITS = $clog2(MAX_SIDE);
   localparam int ADDR_W    = 2 * SIDE_BITS;
   localparam int SUM_W     = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 12;

   logic advance;

   // stage 1: products
   logic                     b1_valid_ff;
   item_type                 b1_item_ff;
   logic signed [PROD_W-1:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;

   // stage 2: mapped coordinates in fixed point
   logic                    b2_valid_ff;
   item_type                b2_item_ff;
   logic signed [SUM_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic signed [SUM_W-1:0] cen_x, cen_y;

   // stage 3: store access
   logic                    b3_valid_ff;
   logic                    b3_render_ff;
   logic                    b3_inside_ff;
   logic [COORD_W-1:0]      lim_x, lim_y;
   logic signed [SUM_W-1:0] lim_sh_x, lim_sh_y;
   logic                    inside_x, inside_y, hit;
   logic [SIDE_BITS-1:0]    idx_x, idx_y;
   logic                    ram_en;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_addr;
   logic [PIXEL_W-1:0]      ram_rdata;

   // output register
   logic               out_valid_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic               out_inside_ff;

   assign advance = !out_valid_ff || rsp_ready;
   assign q_pop   = advance && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= !q_status.empty;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         out_valid_ff <= b3_valid_ff && b3_render_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_item_ff <= q_item;
         pxc_ff <= PROD_W'(q_item.a) * PROD_W'(cfg.cos_angle);
         pys_ff <= PROD_W'(q_item.b) * PROD_W'(cfg.sin_angle);
         pxs_ff <= PROD_W'(q_item.a) * PROD_W'(cfg.sin_angle);
         pyc_ff <= PROD_W'(q_item.b) * PROD_W'(cfg.cos_angle);
      end
   end

   assign cen_x = $signed(SUM_W'(cfg.src_width[COORD_W-1:1]) << FRAC_BITS);
   assign cen_y = $signed(SUM_W'(cfg.src_height[COORD_W-1:1]) << FRAC_BITS);
   assign nx_in = SUM_W'(pxc_ff) - SUM_W'(pys_ff) + cen_x;
   assign ny_in = SUM_W'(pxs_ff) + SUM_W'(pyc_ff) + cen_y;

   always_ff @(posedge clock) begin
      if (advance) begin
         b2_item_ff <= b1_item_ff;
         nx_ff      <= nx_in;
         ny_ff      <= ny_in;
      end
   end

   // truncation toward zero: inside when -1 < v / 2^F < lim
   always_comb begin
      lim_x    = side_limit(cfg.src_width, MAX_SIDE);
      lim_y    = side_limit(cfg.src_height, MAX_SIDE);
      lim_sh_x = $signed(SUM_W'(lim_x) << FRAC_BITS);
      lim_sh_y = $signed(SUM_W'(lim_y) << FRAC_BITS);
      inside_x = (!nx_ff[SUM_W-1] ||
                  ((&nx_ff[SUM_W-1:FRAC_BITS]) && (|nx_ff[FRAC_BITS-1:0]))) &&
                 (nx_ff < lim_sh_x) && (lim_x != '0);
      inside_y = (!ny_ff[SUM_W-1] ||
                  ((&ny_ff[SUM_W-1:FRAC_BITS]) && (|ny_ff[FRAC_BITS-1:0]))) &&
                 (ny_ff < lim_sh_y) && (lim_y != '0);
      hit      = inside_x && inside_y;
      idx_x    = nx_ff[SUM_W-1] ? '0 : nx_ff[FRAC_BITS+SIDE_BITS-1:FRAC_BITS];
      idx_y    = ny_ff[SUM_W-1] ? '0 : ny_ff[FRAC_BITS+SIDE_BITS-1:FRAC_BITS];
      ram_we   = !b2_item_ff.is_render;
      ram_en   = advance && b2_valid_ff && (ram_we || hit);
      if (ram_we) begin
         ram_addr = {b2_item_ff.b[SIDE_BITS-1:0], b2_item_ff.a[SIDE_BITS-1:0]};
      end else begin
         ram_addr = {idx_y, idx_x};
      end
   end

   nnr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (1 << ADDR_W)
   ) u_image (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (b2_item_ff.pixel),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         b3_render_ff <= b2_item_ff.is_render;
         b3_inside_ff <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pixel_ff  <= b3_inside_ff ? format_pixel(ram_rdata) : WHITE_PIXEL;
         out_inside_ff <= b3_inside_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign pixel_out = out_pixel_ff;
   assign in_source = out_inside_ff;

endmodule
